### hdl/hsss_pkg.sv
// ----------------------------------------------------------------------------
// hsss_pkg
// Shared types, codes and the half-step coil table for the stepper sequencer.
// ----------------------------------------------------------------------------
package hsss_pkg;

  localparam int unsigned STEP_DELAY_W = 16;
  localparam int unsigned TRIGGER_W    = 10;
  localparam int unsigned TARGET_W     = 16;
  localparam int unsigned SENSOR_W     = 10;
  localparam int unsigned COUNT_W      = 17;
  localparam int unsigned PHASE_W      = 3;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned CFG_INDEX_W  = 1;

  // Step limit for the one-turn and homing runs.
  localparam logic [COUNT_W-1:0] STEPS_PER_TURN = 17'd4096;
  // Last phase of an eight-phase group.
  localparam logic [PHASE_W-1:0] LAST_PHASE     = 3'd7;

  localparam logic [STEP_DELAY_W-1:0] STEP_DELAY_RESET = 16'd1;
  localparam logic [TRIGGER_W-1:0]    TRIGGER_RESET    = 10'd512;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_FWD_COUNT = 3'd1,
    OP_FWD_TURN  = 3'd2,
    OP_REV_TURN  = 3'd3,
    OP_HOMING    = 3'd4,
    OP_STOP      = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_FWD_COUNT = 3'd1,
    MODE_FWD_TURN  = 3'd2,
    MODE_REV_TURN  = 3'd3,
    MODE_HOMING    = 3'd4
  } mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_STEP_DELAY    = 1'd0,
    REG_TRIGGER_LEVEL = 1'd1
  } reg_index_t;

  typedef struct packed {
    logic [3:0]         coils;
    logic               running;
    logic [COUNT_W-1:0] step_total;
    logic               run_ended;
  } result_t;

  // Half-step pattern, bit3 first coil through bit0 fourth coil.
  function automatic logic [3:0] phase_coils(input logic [PHASE_W-1:0] idx);
    logic [3:0] pat;
    case (idx)
      3'd0:    pat = 4'h9;
      3'd1:    pat = 4'h8;
      3'd2:    pat = 4'hC;
      3'd3:    pat = 4'h4;
      3'd4:    pat = 4'h6;
      3'd5:    pat = 4'h2;
      3'd6:    pat = 4'h3;
      default: pat = 4'h1;
    endcase
    return pat;
  endfunction

endpackage

### hdl/hsss_if.sv
// ----------------------------------------------------------------------------
// hsss_if
// Valid/ready channels carrying command beats in and status beats out.
// ----------------------------------------------------------------------------
interface hsss_in_if import hsss_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [2:0]          opcode;
  logic [TARGET_W-1:0] target_steps;
  logic [SENSOR_W-1:0] sensor_level;

  modport source (output valid, output opcode, output target_steps,
                  output sensor_level, input ready);
  modport sink   (input valid, input opcode, input target_steps,
                  input sensor_level, output ready);
endinterface

interface hsss_out_if import hsss_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [3:0]         coils;
  logic               running;
  logic [COUNT_W-1:0] step_total;
  logic               run_ended;

  modport source (output valid, output coils, output running,
                  output step_total, output run_ended, input ready);
  modport sink   (input valid, input coils, input running,
                  input step_total, input run_ended, output ready);
endinterface

### hdl/hsss_core.sv
// ----------------------------------------------------------------------------
// hsss_core
// Run state, configuration registers and the per-beat next-state logic.
// ----------------------------------------------------------------------------
module hsss_core import hsss_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    accept,
  input  logic [2:0]              opcode,
  input  logic [TARGET_W-1:0]     target_steps,
  input  logic [SENSOR_W-1:0]     sensor_level,
  output result_t                 result
);

  logic [STEP_DELAY_W-1:0] step_delay;
  logic [TRIGGER_W-1:0]    trigger_level;

  logic [PHASE_W-1:0]      phase_index, phase_index_next;
  logic [COUNT_W-1:0]      step_count, step_count_next;
  logic [STEP_DELAY_W-1:0] hold_timer, hold_timer_next;
  mode_t                   run_mode, run_mode_next;
  logic [COUNT_W-1:0]      step_limit, step_limit_next;
  logic [3:0]              coil_pattern, coil_pattern_next;
  logic                    ended;

  logic [STEP_DELAY_W-1:0] load_delay;
  logic                    sensor_high;
  logic                    forward;
  logic [PHASE_W-1:0]      next_pos;
  logic [PHASE_W-1:0]      table_idx;

  assign load_delay  = (step_delay == '0) ? STEP_DELAY_W'(1) : step_delay;
  assign sensor_high = sensor_level > trigger_level;

  always_comb begin
    phase_index_next  = phase_index;
    step_count_next   = step_count;
    hold_timer_next   = hold_timer;
    run_mode_next     = run_mode;
    step_limit_next   = step_limit;
    coil_pattern_next = coil_pattern;
    ended             = 1'b0;
    next_pos          = '0;
    forward           = 1'b0;
    table_idx         = '0;

    case (opcode)
      OP_STOP: begin
        ended             = (run_mode != MODE_IDLE);
        phase_index_next  = '0;
        step_count_next   = '0;
        hold_timer_next   = '0;
        run_mode_next     = MODE_IDLE;
        step_limit_next   = '0;
        coil_pattern_next = 4'h0;
      end
      OP_FWD_COUNT, OP_FWD_TURN, OP_REV_TURN, OP_HOMING: begin
        if (run_mode == MODE_IDLE) begin
          // Count is zero at start, so only the homing sensor can refuse it.
          forward = (opcode == OP_FWD_COUNT) || (opcode == OP_FWD_TURN);
          if ((opcode == OP_HOMING) && sensor_high) begin
            ended = 1'b1;
          end else begin
            run_mode_next     = mode_t'(opcode);
            step_limit_next   = (opcode == OP_FWD_COUNT) ?
                                {1'b0, target_steps} : STEPS_PER_TURN;
            phase_index_next  = '0;
            table_idx         = forward ? '0 : LAST_PHASE;
            coil_pattern_next = phase_coils(table_idx);
            step_count_next   = COUNT_W'(1);
            hold_timer_next   = load_delay;
          end
        end
      end
      OP_TICK: begin
        if (run_mode != MODE_IDLE) begin
          forward = (run_mode == MODE_FWD_COUNT) || (run_mode == MODE_FWD_TURN);
          if (hold_timer > STEP_DELAY_W'(1)) begin
            hold_timer_next = hold_timer - STEP_DELAY_W'(1);
          end else if (phase_index == LAST_PHASE &&
                       ((step_count > step_limit) ||
                        ((run_mode == MODE_HOMING) && sensor_high))) begin
            // Group check failed: end the run.
            ended             = 1'b1;
            phase_index_next  = '0;
            step_count_next   = '0;
            hold_timer_next   = '0;
            run_mode_next     = MODE_IDLE;
            step_limit_next   = '0;
            coil_pattern_next = 4'h0;
          end else begin
            next_pos          = (phase_index == LAST_PHASE) ? '0
                                : phase_index + PHASE_W'(1);
            table_idx         = forward ? next_pos : (LAST_PHASE - next_pos);
            phase_index_next  = next_pos;
            coil_pattern_next = phase_coils(table_idx);
            step_count_next   = step_count + COUNT_W'(1);
            hold_timer_next   = load_delay;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign result.coils      = coil_pattern_next;
  assign result.running    = (run_mode_next != MODE_IDLE);
  assign result.step_total = step_count_next;
  assign result.run_ended  = ended;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_delay    <= STEP_DELAY_RESET;
      trigger_level <= TRIGGER_RESET;
      phase_index   <= '0;
      step_count    <= '0;
      hold_timer    <= '0;
      run_mode      <= MODE_IDLE;
      step_limit    <= '0;
      coil_pattern  <= 4'h0;
    end else begin
      if (cfg_we) begin
        unique case (reg_index_t'(cfg_index))
          REG_STEP_DELAY:    step_delay    <= cfg_data;
          REG_TRIGGER_LEVEL: trigger_level <= cfg_data[TRIGGER_W-1:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        phase_index  <= phase_index_next;
        step_count   <= step_count_next;
        hold_timer   <= hold_timer_next;
        run_mode     <= run_mode_next;
        step_limit   <= step_limit_next;
        coil_pattern <= coil_pattern_next;
      end
    end
  end

endmodule

### hdl/hsss_out_buf.sv
// ----------------------------------------------------------------------------
// hsss_out_buf
// Two-entry result buffer; keeps the input open during sink stalls until full.
// ----------------------------------------------------------------------------
module hsss_out_buf import hsss_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    can_push,
  output logic    pop_valid,
  input  logic    pop,
  output result_t pop_data
);

  result_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign can_push  = (count != 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/half_step_stepper_sequencer.sv
// ----------------------------------------------------------------------------
// half_step_stepper_sequencer
// Four-coil stepper driver with the eight-phase half-step sequence.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one beat per tick or command (opcode, target_steps,
//   sensor_level). Every accepted beat yields exactly one status beat on
//   out_ch: coil drive, running flag, phases stepped and a run-ended flag.
//   The user writes step_delay and trigger_level through cfg_we/cfg_index/
//   cfg_data only while the block is idle; the block does not enforce it.
// Timing:
//   Status beats are registered and leave out_ch in accept order. One beat
//   is taken every cycle while the buffer has room; the run state updates
//   in one pass of logic from the state registers to the result buffer.
// Reset:
//   rst (synchronous) stops any run, clears the coils and count, loads
//   step_delay 1 and trigger_level 512, and empties the result buffer.
// Stall:
//   Up to two status beats wait in the result buffer; in_ch.ready drops only
//   while both are held and rises again as soon as out_ch takes one.
// ----------------------------------------------------------------------------
module half_step_stepper_sequencer import hsss_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  hsss_in_if.sink                in_ch,
  hsss_out_if.source             out_ch
);

  logic    accept;
  logic    can_push;
  result_t result;
  result_t head;

  assign in_ch.ready = can_push;
  assign accept      = in_ch.valid && can_push;

  hsss_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .opcode       (in_ch.opcode),
    .target_steps (in_ch.target_steps),
    .sensor_level (in_ch.sensor_level),
    .result       (result)
  );

  hsss_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .can_push  (can_push),
    .pop_valid (out_ch.valid),
    .pop       (out_ch.valid && out_ch.ready),
    .pop_data  (head)
  );

  assign out_ch.coils      = head.coils;
  assign out_ch.running    = head.running;
  assign out_ch.step_total = head.step_total;
  assign out_ch.run_ended  = head.run_ended;

endmodule

### hdl/hsss_checker.sv
// ----------------------------------------------------------------------------
// hsss_checker
// Port-level checks on the status beats of the stepper sequencer.
// ----------------------------------------------------------------------------
module hsss_checker import hsss_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [3:0]         coils,
  input logic               running,
  input logic [COUNT_W-1:0] step_total,
  input logic               run_ended
);

  // An ended run shows cleared coils and count.
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && run_ended |-> !running && coils == 4'h0 && step_total == '0)
    else $error("run end beat does not show a cleared state");

  // Idle drives no coil and reports no steps.
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !running |-> coils == 4'h0 && step_total == '0)
    else $error("idle beat with coils or count set");

  // A running beat always drives a phase and has counted it.
  a_run_active: assert property (@(posedge clk) disable iff (rst)
    out_valid && running |-> coils != 4'h0 && step_total != '0 && !run_ended)
    else $error("running beat without a driven phase");

  // Hold a stalled beat.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(coils) && $stable(running)
      && $stable(step_total) && $stable(run_ended))
    else $error("stalled status beat changed");

  // Reset empties the result buffer.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("status beat valid right after reset");

endmodule

bind half_step_stepper_sequencer hsss_checker u_hsss_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .coils      (out_ch.coils),
  .running    (out_ch.running),
  .step_total (out_ch.step_total),
  .run_ended  (out_ch.run_ended)
);

### tb/sv/hsss_status_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsss_status_check
// Watches the command and status channels of the stepper sequencer, keeps its
// own copy of the run state and registers, predicts one status beat for every
// command beat taken and compares each status beat field by field.
// ----------------------------------------------------------------------------
module hsss_status_check import hsss_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  hsss_in_if                     in_ch,
  hsss_out_if                    out_ch,
  output int unsigned            fail_count,
  output int unsigned            beats_due
);

  // Half-step coil patterns, phase 0 in the low nibble.
  localparam logic [31:0] HALF_STEP = 32'h1326_4C89;
  localparam int unsigned MAX_PRINTED = 200;

  logic [STEP_DELAY_W-1:0] hold_ticks;
  logic [TRIGGER_W-1:0]    trip_level;
  logic [PHASE_W-1:0]      phase_pos;
  logic [COUNT_W-1:0]      phases_done;
  logic [STEP_DELAY_W-1:0] hold_left;
  mode_t                   mode;
  logic [COUNT_W-1:0]      phase_limit;
  logic [3:0]              coil_drive;
  result_t                 status_due[$];
  int unsigned             errors = 0;

  task automatic report_mismatch(input string what);
    errors++;
    // keep the log short when the block is badly broken
    if (errors <= MAX_PRINTED)
      $display("[%0t] status mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  function automatic bit group_allowed(input logic [SENSOR_W-1:0] sensor);
    return !(phases_done > phase_limit) && !(mode == MODE_HOMING && sensor > trip_level);
  endfunction

  task automatic stop_run();
    coil_drive  = '0;
    phases_done = '0;
    phase_pos   = '0;
    hold_left   = '0;
    mode        = MODE_IDLE;
    phase_limit = '0;
  endtask

  task automatic load_phase();
    logic [PHASE_W-1:0] idx;
    // reverse runs walk the table from the far end
    idx = (mode == MODE_FWD_COUNT || mode == MODE_FWD_TURN) ? phase_pos
                                                           : LAST_PHASE - phase_pos;
    coil_drive  = HALF_STEP[{idx, 2'b00} +: 4];
    phases_done = phases_done + 1'b1;
    hold_left   = (hold_ticks == '0) ? STEP_DELAY_W'(1) : hold_ticks;
  endtask

  task automatic advance_sequencer(input logic [2:0] op, input logic [TARGET_W-1:0] target,
                                   input logic [SENSOR_W-1:0] sensor, output result_t res);
    logic ended;
    ended = 1'b0;
    case (op)
      OP_STOP: begin
        ended = (mode != MODE_IDLE);
        stop_run();
      end
      OP_FWD_COUNT, OP_FWD_TURN, OP_REV_TURN, OP_HOMING: begin
        // a start while running is dropped
        if (mode == MODE_IDLE) begin
          mode        = mode_t'(op);
          phase_limit = (op == OP_FWD_COUNT) ? {1'b0, target} : STEPS_PER_TURN;
          phases_done = '0;
          phase_pos   = '0;
          if (group_allowed(sensor)) begin
            load_phase();
          end else begin
            stop_run();
            ended = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (mode != MODE_IDLE) begin
          if (hold_left > STEP_DELAY_W'(1)) begin
            hold_left = hold_left - 1'b1;
          end else if (phase_pos == LAST_PHASE) begin
            // group boundary: check limit and sensor before the next group
            phase_pos = '0;
            if (group_allowed(sensor)) begin
              load_phase();
            end else begin
              stop_run();
              ended = 1'b1;
            end
          end else begin
            phase_pos = phase_pos + 1'b1;
            load_phase();
          end
        end
      end
      default: ;
    endcase
    res.coils      = coil_drive;
    res.running    = (mode != MODE_IDLE);
    res.step_total = phases_done;
    res.run_ended  = ended;
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    result_t next_status;
    if (rst) begin
      hold_ticks = STEP_DELAY_RESET;
      trip_level = TRIGGER_RESET;
      stop_run();
      status_due.delete();
    end else begin
      // compare first: a status beat can never belong to a command taken this edge
      if (out_ch.valid && out_ch.ready) begin
        if (status_due.size() == 0) begin
          report_mismatch("status beat with none expected");
        end else begin
          want = status_due.pop_front();
          check_field("coils", out_ch.coils, want.coils);
          check_field("running", out_ch.running, want.running);
          check_field("step_total", out_ch.step_total, want.step_total);
          check_field("run_ended", out_ch.run_ended, want.run_ended);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        advance_sequencer(in_ch.opcode, in_ch.target_steps, in_ch.sensor_level, next_status);
        status_due.push_back(next_status);
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_STEP_DELAY:    hold_ticks = cfg_data;
          REG_TRIGGER_LEVEL: trip_level = cfg_data[TRIGGER_W-1:0];
          default: ;
        endcase
      end
    end
    fail_count <= errors;
    beats_due  <= status_due.size();
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the stepper sequencer with directed commands and then random runs
// under several register settings, with random gaps on both channels and one
// long status hold-off; the status check module judges every beat.
// ----------------------------------------------------------------------------
module testbench;
  import hsss_pkg::*;

  // Opcodes with no function in the block.
  localparam logic [2:0]  OP_SPARE_A      = 3'd6;
  localparam logic [2:0]  OP_SPARE_B      = 3'd7;
  localparam int unsigned PHASE_COUNT     = 10;
  localparam int unsigned PHASE_BEATS     = 140;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned MAX_GAP         = 19;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int unsigned            fail_count;
  int unsigned            beats_due;
  int unsigned            beats_sent   = 0;
  bit                     src_gaps     = 1'b1;
  bit                     sink_gaps    = 1'b1;
  bit                     hold_off_req = 1'b0;
  logic [TRIGGER_W-1:0]   trig_now     = TRIGGER_RESET;

  hsss_in_if  in_ch ();
  hsss_out_if out_ch ();

  half_step_stepper_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  hsss_status_check status_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .beats_due  (beats_due)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Status side: random stall before each beat, one long hold-off on request.
  initial begin : drain
    int unsigned gap;
    out_ch.ready <= 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        gap = HOLD_OFF_CYCLES;
      end else begin
        gap = sink_gaps ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk iff out_ch.valid);
    end
  end

  task automatic send_beat(input logic [2:0] op, input logic [TARGET_W-1:0] target,
                           input logic [SENSOR_W-1:0] sensor);
    int unsigned gap;
    gap = src_gaps ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.target_steps <= target;
    in_ch.sensor_level <= sensor;
    @(posedge clk iff in_ch.ready);
    beats_sent++;
  endtask

  task automatic drain_wait();
    in_ch.valid <= 1'b0;
    @(posedge clk iff beats_due == 0);
  endtask

  task automatic load_config(input logic [STEP_DELAY_W-1:0] delay,
                             input logic [TRIGGER_W-1:0] trig);
    drain_wait();
    cfg_we    <= 1'b1;
    cfg_index <= REG_STEP_DELAY;
    cfg_data  <= delay;
    @(posedge clk);
    cfg_index <= REG_TRIGGER_LEVEL;
    cfg_data  <= CFG_DATA_W'(trig);
    @(posedge clk);
    cfg_we    <= 1'b0;
    trig_now = trig;
  endtask

  // Sensor level for a homing run; trips the trigger when asked and possible.
  function automatic logic [SENSOR_W-1:0] homing_sensor(input bit trip);
    if (trip && trig_now != '1)
      return SENSOR_W'($urandom_range(trig_now + 1, 1023));
    return SENSOR_W'($urandom_range(0, trig_now));
  endfunction

  // One start command, a stretch of ticks with some noise, usually a stop; now and then one random beat alone.
  task automatic random_run();
    logic [2:0]          op;
    logic [TARGET_W-1:0] target;
    logic [SENSOR_W-1:0] level;
    int unsigned         ticks, trip_at, pick, i;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_beat(3'($urandom_range(OP_TICK, OP_SPARE_B)), 16'($urandom), 10'($urandom));
      return;
    end
    case ($urandom_range(0, 5))
      0, 1, 2: op = OP_FWD_COUNT;
      3:       op = OP_FWD_TURN;
      4:       op = OP_REV_TURN;
      default: op = OP_HOMING;
    endcase
    target  = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
    ticks   = $urandom_range(1, 110);
    trip_at = (op == OP_HOMING) ? $urandom_range(0, ticks + 20) : ticks + 1;
    level   = (op == OP_HOMING) ? homing_sensor(trip_at == 0) : 10'($urandom);
    send_beat(op, target, level);
    for (i = 1; i <= ticks; i++) begin
      pick  = $urandom_range(0, 99);
      level = (op == OP_HOMING) ? homing_sensor(i >= trip_at) : 10'($urandom);
      if (pick < 3)
        send_beat(3'($urandom_range(OP_FWD_COUNT, OP_HOMING)), 16'($urandom), level);
      else if (pick < 5)
        send_beat(pick[0] ? OP_SPARE_A : OP_SPARE_B, 16'($urandom), level);
      else
        send_beat(OP_TICK, 16'($urandom), level);
    end
    if ($urandom_range(0, 3) != 0)
      send_beat(OP_STOP, 16'($urandom), 10'($urandom));
  endtask

  initial begin : stimulus
    int unsigned             ph, phase_end;
    logic [STEP_DELAY_W-1:0] delay;
    logic [TRIGGER_W-1:0]    trig;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_STEP_DELAY;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= OP_TICK;
    in_ch.target_steps <= '0;
    in_ch.sensor_level <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    load_config(STEP_DELAY_RESET, TRIGGER_RESET);
    // idle: tick, stop and spare opcodes change nothing
    send_beat(OP_TICK, '0, '0);
    send_beat(OP_STOP, '1, '1);
    send_beat(OP_SPARE_A, '1, '0);
    send_beat(OP_SPARE_B, '0, '1);
    // zero target: one whole group, then the limit ends the run
    send_beat(OP_FWD_COUNT, '0, '0);
    repeat (8) send_beat(OP_TICK, '0, '1);
    // homing with the sensor above the trigger ends at once
    send_beat(OP_HOMING, '0, 10'd1023);
    // starts and spare opcodes while running are dropped, stop ends the run
    send_beat(OP_REV_TURN, '0, '0);
    send_beat(OP_FWD_TURN, '1, '0);
    send_beat(OP_SPARE_A, '0, '0);
    send_beat(OP_TICK, '0, '0);
    send_beat(OP_STOP, '0, '0);
    // sensor equal to the trigger still lets homing run
    send_beat(OP_HOMING, '0, TRIGGER_RESET);
    send_beat(OP_TICK, '0, TRIGGER_RESET);
    send_beat(OP_STOP, '0, '0);
    // leave a long run going so the next register write lands mid-run
    send_beat(OP_FWD_COUNT, '1, '0);
    send_beat(OP_TICK, '0, '0);

    for (ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0:       begin delay = '0;    trig = '0;    end
        1:       begin delay = 16'd1; trig = '1;    end
        2:       begin delay = 16'd2; trig = 10'd300; end
        3:       begin delay = '1;    trig = TRIGGER_RESET; end
        4:       begin delay = 16'd3; trig = 10'($urandom); end
        default: begin
          delay = 16'($urandom_range(1, 4));
          trig  = 10'($urandom);
        end
      endcase
      src_gaps  = (ph % 3 != 1) && (ph != 8);
      sink_gaps = (ph % 3 != 1) && (ph != 5);
      load_config(delay, trig);
      if (ph == 2) begin
        // back-to-back commands against a long status hold-off
        src_gaps     = 1'b0;
        hold_off_req = 1'b1;
      end
      phase_end = beats_sent + PHASE_BEATS;
      while (beats_sent < phase_end)
        random_run();
    end

    drain_wait();
    repeat (4) @(posedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
